[sv/sstf_disk_request_scheduler_macros.svh]
// Shared assertion macros for the scheduler.
`ifndef SSTF_DISK_REQUEST_SCHEDULER_MACROS_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle.
`define SSTF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the following cycle.
`define SSTF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/sstf_pkg.sv]
package sstf_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = 6;
   localparam int COUNT_W     = 7;
   localparam int TRACK_W     = 8;
   localparam int SEEK_W      = 14;

   localparam logic [TRACK_W-1:0] START_HEAD_RESET = 8'd50;

   typedef struct packed {
      logic load;
      logic init;
      logic issue;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic final_pick;
   } status_type;

endpackage

[sv/sstf_disk_request_scheduler.sv]
// Shortest-seek-first disk request scheduler.
// Input: present a request on req_track / req_batch_end with start high; it is
// taken at a rising edge where start is high and busy is low. Requests load
// one per cycle into a table of MAX_REQUESTS entries, at most 64; extra
// requests are dropped and reported on rsp_overflow for the rest of the batch.
// A request with req_batch_end set closes the batch; busy rises on the next
// cycle and the block serves every loaded request, nearest to the head first,
// ties to the earliest loaded, starting from the head at csr_wr_data's last
// written value (50 after reset).
// Output: each served request appears for one cycle with rsp_strobe high,
// carrying the track, the running seek total and the overflow flag;
// rsp_final_res marks the last beat of the batch. The receiver cannot stall.
// Timing: each pick scans the table through one memory read port, one entry
// per cycle, then passes through the SETTLE and EMIT states before the next
// pick. busy falls with the final beat.
// Reset: synchronous, active high; clears the batch and sets the start head
// to 50. The table contents are not cleared.
module sstf_disk_request_scheduler #(
   parameter int MAX_REQUESTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [sstf_pkg::TRACK_W-1:0]  req_track,
   input  logic                          req_batch_end,
   output logic                          rsp_strobe,
   output logic [sstf_pkg::TRACK_W-1:0]  rsp_served_track,
   output logic [sstf_pkg::SEEK_W-1:0]   rsp_seek_total,
   output logic                          rsp_overflow,
   output logic                          rsp_final_res,
   input  logic                          csr_wr_en,
   input  logic [sstf_pkg::TRACK_W-1:0]  csr_wr_data
);
   import sstf_pkg::*;

   cmd_type    cmd;
   status_type status;

   sstf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_batch_end (req_batch_end),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   sstf_datapath #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_track        (req_track),
      .rsp_strobe       (rsp_strobe),
      .rsp_served_track (rsp_served_track),
      .rsp_seek_total   (rsp_seek_total),
      .rsp_overflow     (rsp_overflow),
      .rsp_final_res    (rsp_final_res)
   );

endmodule

[sv/sstf_ctrl.sv]
module sstf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_batch_end,
   input  sstf_pkg::status_type status,
   output sstf_pkg::cmd_type    cmd,
   output logic                 busy
);
   import sstf_pkg::*;
   `include "sstf_disk_request_scheduler_macros.svh"

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      SETTLE,
      EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      unique case (state_ff)
         IDLE: begin
            cmd.load = start;
            if (start && req_batch_end) begin
               cmd.init = 1'b1;
               state_in = SCAN;
            end
         end
         SCAN: begin
            cmd.issue = 1'b1;
            if (status.scan_last) begin
               state_in = SETTLE;
            end
         end
         SETTLE: begin
            state_in = EMIT;
         end
         EMIT: begin
            cmd.emit = 1'b1;
            state_in = status.final_pick ? IDLE : SCAN;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != IDLE);
      end
   end

   assign busy = busy_ff;

   `SSTF_ASSERT_NEXT(a_batch_end_starts_scan, start && !busy_ff && req_batch_end,
      state_ff == SCAN && busy_ff, "batch end did not start a scan")
   `SSTF_ASSERT_NOW(a_idle_not_busy, state_ff == IDLE, !busy_ff,
      "busy while idle")
   `SSTF_ASSERT_NEXT(a_scan_end_settles, state_ff == SCAN && status.scan_last,
      state_ff == SETTLE, "scan end did not settle")

endmodule

[sv/sstf_datapath.sv]
module sstf_datapath #(
   parameter int MAX_REQUESTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sstf_pkg::cmd_type             cmd,
   output sstf_pkg::status_type          status,
   input  logic                          csr_wr_en,
   input  logic [sstf_pkg::TRACK_W-1:0]  csr_wr_data,
   input  logic [sstf_pkg::TRACK_W-1:0]  req_track,
   output logic                          rsp_strobe,
   output logic [sstf_pkg::TRACK_W-1:0]  rsp_served_track,
   output logic [sstf_pkg::SEEK_W-1:0]   rsp_seek_total,
   output logic                          rsp_overflow,
   output logic                          rsp_final_res
);
   import sstf_pkg::*;
   `include "sstf_disk_request_scheduler_macros.svh"

   localparam int CAP = (MAX_REQUESTS > TABLE_DEPTH) ? TABLE_DEPTH :
                        (MAX_REQUESTS < 1) ? 1 : MAX_REQUESTS;
   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAP);

   logic [TRACK_W-1:0]     table_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] served_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   dropped_ff;
   logic [TRACK_W-1:0]     start_head_ff;
   logic [TRACK_W-1:0]     head_ff;
   logic [SEEK_W-1:0]      seek_ff;
   logic [COUNT_W-1:0]     pick_ff;
   logic [COUNT_W-1:0]     scan_ff;
   logic                   rd_valid_ff;
   logic [ADDR_W-1:0]      rd_idx_ff;
   logic [TRACK_W-1:0]     rd_data_ff;
   logic                   found_ff;
   logic [ADDR_W-1:0]      best_idx_ff;
   logic [TRACK_W-1:0]     best_track_ff;
   logic [TRACK_W-1:0]     best_dist_ff;
   logic                   rsp_strobe_ff;
   logic [TRACK_W-1:0]     rsp_track_ff;
   logic [SEEK_W-1:0]      rsp_seek_ff;
   logic                   rsp_overflow_ff;
   logic                   rsp_final_ff;

   logic [TRACK_W-1:0]     seek_gap;
   logic                   better;
   logic [SEEK_W-1:0]      seek_in;
   logic                   final_pick;

   assign seek_gap   = (rd_data_ff >= head_ff) ? (rd_data_ff - head_ff)
                                               : (head_ff - rd_data_ff);
   assign better     = rd_valid_ff && !served_ff[rd_idx_ff]
                       && (!found_ff || seek_gap < best_dist_ff);
   assign seek_in    = seek_ff + SEEK_W'(best_dist_ff);
   assign final_pick = (pick_ff + COUNT_W'(1)) == count_ff;

   assign status.scan_last  = (scan_ff == count_ff - COUNT_W'(1));
   assign status.final_pick = final_pick;

   // table write and registered read
   always_ff @(posedge clock) begin
      if (cmd.load && count_ff < CAP_COUNT) begin
         table_mem[count_ff[ADDR_W-1:0]] <= req_track;
      end
      rd_data_ff <= table_mem[scan_ff[ADDR_W-1:0]];
      rd_idx_ff  <= scan_ff[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_head_ff <= START_HEAD_RESET;
      end else if (csr_wr_en) begin
         start_head_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         served_ff     <= '0;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         head_ff       <= START_HEAD_RESET;
         seek_ff       <= '0;
         pick_ff       <= '0;
         scan_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.issue;
         rsp_strobe_ff <= cmd.emit;
         if (cmd.load) begin
            if (count_ff < CAP_COUNT) begin
               count_ff <= count_ff + COUNT_W'(1);
            end else begin
               dropped_ff <= 1'b1;
            end
         end
         if (cmd.init) begin
            head_ff  <= start_head_ff;
            seek_ff  <= '0;
            pick_ff  <= '0;
            scan_ff  <= '0;
            found_ff <= 1'b0;
         end
         if (cmd.issue) begin
            scan_ff <= scan_ff + COUNT_W'(1);
         end
         if (better) begin
            found_ff <= 1'b1;
         end
         if (cmd.emit) begin
            seek_ff  <= seek_in;
            pick_ff  <= pick_ff + COUNT_W'(1);
            scan_ff  <= '0;
            found_ff <= 1'b0;
            if (final_pick) begin
               served_ff  <= '0;
               count_ff   <= '0;
               dropped_ff <= 1'b0;
               head_ff    <= start_head_ff;
            end else begin
               served_ff[best_idx_ff] <= 1'b1;
               head_ff                <= best_track_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (better) begin
         best_idx_ff   <= rd_idx_ff;
         best_track_ff <= rd_data_ff;
         best_dist_ff  <= seek_gap;
      end
      if (cmd.emit) begin
         rsp_track_ff    <= best_track_ff;
         rsp_seek_ff     <= seek_in;
         rsp_overflow_ff <= dropped_ff;
         rsp_final_ff    <= final_pick;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_served_track = rsp_track_ff;
   assign rsp_seek_total   = rsp_seek_ff;
   assign rsp_overflow     = rsp_overflow_ff;
   assign rsp_final_res    = rsp_final_ff;

   `SSTF_ASSERT_NOW(a_emit_has_pick, cmd.emit, found_ff, "pick without candidate")
   `SSTF_ASSERT_NOW(a_scan_in_range, cmd.issue, scan_ff < count_ff,
      "scan index past request count")
   `SSTF_ASSERT_NEXT(a_final_clears, cmd.emit && final_pick,
      count_ff == '0 && served_ff == '0, "batch state not cleared")

endmodule

[dv/tb_sstf_disk_request_scheduler.sv]
`timescale 1ns / 1ps

module tb_sstf_disk_request_scheduler;
   import sstf_pkg::*;

   localparam int MAX_REQ           = 64;
   localparam int SENDER_IDLE_LIGHT = 35;
   localparam int SENDER_IDLE_HEAVY = 57;
   localparam int SETTLE_CYCLES     = 8;
   localparam int TAIL_CYCLES       = 64;
   localparam int RANDOM_BUDGET     = 30;
   localparam int TIMEOUT_NS        = 5_000_000;

   typedef enum {SPREAD, CLUSTER, EXTREME} track_mix_type;

   typedef struct {
      logic [TRACK_W-1:0] track;
      logic               batch_end;
      logic               settle;
   } request_type;

   typedef struct {
      logic [TRACK_W-1:0] served_track;
      logic [SEEK_W-1:0]  seek_total;
      logic               overflow;
      logic               final_res;
   } visit_type;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               start         = 1'b0;
   logic               busy;
   logic [TRACK_W-1:0] req_track     = '0;
   logic               req_batch_end = 1'b0;
   logic               rsp_strobe;
   logic [TRACK_W-1:0] rsp_served_track;
   logic [SEEK_W-1:0]  rsp_seek_total;
   logic               rsp_overflow;
   logic               rsp_final_res;
   logic               csr_wr_en     = 1'b0;
   logic [TRACK_W-1:0] csr_wr_data   = '0;

   request_type        pending_requests[$];
   visit_type          expected_visits[$];
   request_type        on_bus;
   visit_type          next_visit;
   logic [TRACK_W-1:0] batch_tracks[$];
   logic               batch_dropped = 1'b0;
   logic [TRACK_W-1:0] head_setting  = START_HEAD_RESET;
   int                 sender_idle_pct = SENDER_IDLE_LIGHT;
   int                 mismatches      = 0;

   sstf_disk_request_scheduler #(.MAX_REQUESTS(MAX_REQ)) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_track        (req_track),
      .req_batch_end    (req_batch_end),
      .rsp_strobe       (rsp_strobe),
      .rsp_served_track (rsp_served_track),
      .rsp_seek_total   (rsp_seek_total),
      .rsp_overflow     (rsp_overflow),
      .rsp_final_res    (rsp_final_res),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic predict_visits(input request_type r);
      logic               served[MAX_REQ];
      logic [TRACK_W-1:0] head;
      logic [SEEK_W-1:0]  seek;
      int                 best;
      int                 best_dist;
      int                 gap;
      visit_type          v;
      if (batch_tracks.size() < MAX_REQ) batch_tracks.insert(batch_tracks.size(), r.track);
      else batch_dropped = 1'b1;
      if (r.batch_end) begin
         for (int i = 0; i < MAX_REQ; i++) served[i] = 1'b0;
         head = head_setting;
         seek = '0;
         for (int k = 0; k < batch_tracks.size(); k++) begin
            best = -1;
            best_dist = 0;
            for (int i = 0; i < batch_tracks.size(); i++) begin
               if (!served[i]) begin
                  gap = (batch_tracks[i] >= head) ? int'(batch_tracks[i]) - int'(head)
                                                  : int'(head) - int'(batch_tracks[i]);
                  if (best < 0 || gap < best_dist) begin
                     best = i;
                     best_dist = gap;
                  end
               end
            end
            served[best] = 1'b1;
            seek = seek + SEEK_W'(best_dist);
            head = batch_tracks[best];
            v.served_track = head;
            v.seek_total   = seek;
            v.overflow     = batch_dropped;
            v.final_res    = (k == batch_tracks.size() - 1);
            expected_visits.insert(expected_visits.size(), v);
         end
         batch_tracks.delete();
         batch_dropped = 1'b0;
      end
   endtask

   task automatic add_request(input logic [TRACK_W-1:0] t, input logic last,
                              input logic settle = 1'b0);
      request_type r;
      r.track     = t;
      r.batch_end = last;
      r.settle    = settle;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic add_random_batches(input int budget);
      int                 n;
      int                 added;
      int                 batches;
      logic [TRACK_W-1:0] base;
      logic [TRACK_W-1:0] t;
      track_mix_type      mix;
      added = 0;
      batches = 0;
      while (added < budget) begin
         n    = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
         mix  = track_mix_type'($urandom_range(2));
         base = TRACK_W'($urandom_range(255));
         for (int i = 0; i < n; i++) begin
            case (mix)
               SPREAD: begin
                  t = TRACK_W'($urandom_range(255));
               end
               CLUSTER: begin
                  t = base + TRACK_W'($urandom_range(4));
               end
               default: begin
                  case ($urandom_range(2))
                     0: t = '0;
                     1: t = '1;
                     default: t = head_setting;
                  endcase
               end
            endcase
            add_request(t, i == n - 1, batches == 1 && i == 0);
         end
         added += n;
         batches++;
      end
   endtask

   task automatic drain_and_write(input logic [TRACK_W-1:0] value);
      while (pending_requests.size() != 0 || start) @(posedge clock);
      while (expected_visits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      head_setting = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // hold the beat until taken; a settle beat waits for every visit to drain
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) predict_visits(on_bus);
         if (!start || !busy) begin
            if (pending_requests.size() != 0
                && $urandom_range(99) >= sender_idle_pct
                && !(pending_requests[0].settle && expected_visits.size() != 0)) begin
               on_bus = pending_requests.pop_front();
               start         <= 1'b1;
               req_track     <= on_bus.track;
               req_batch_end <= on_bus.batch_end;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_visits.size() == 0) begin
            report_mismatch($sformatf("unexpected beat, track %0d seek %0d",
                                      rsp_served_track, rsp_seek_total));
         end else begin
            next_visit = expected_visits.pop_front();
            if (rsp_served_track !== next_visit.served_track)
               report_mismatch($sformatf("served_track %0d, want %0d",
                                         rsp_served_track, next_visit.served_track));
            if (rsp_seek_total !== next_visit.seek_total)
               report_mismatch($sformatf("seek_total %0d, want %0d",
                                         rsp_seek_total, next_visit.seek_total));
            if (rsp_overflow !== next_visit.overflow)
               report_mismatch($sformatf("overflow %0b, want %0b",
                                         rsp_overflow, next_visit.overflow));
            if (rsp_final_res !== next_visit.final_res)
               report_mismatch($sformatf("final_res %0b, want %0b",
                                         rsp_final_res, next_visit.final_res));
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = SENDER_IDLE_LIGHT;
      add_request(8'd0, 1'b1);
      add_request(8'd255, 1'b1);
      add_request(8'd50, 1'b1);
      add_request(8'd40, 1'b0);
      add_request(8'd60, 1'b0);
      add_request(8'd45, 1'b0);
      add_request(8'd55, 1'b1);
      add_request(8'd70, 1'b0);
      add_request(8'd70, 1'b0);
      add_request(8'd30, 1'b1);
      add_request(8'd255, 1'b0);
      add_request(8'd0, 1'b0);
      add_request(8'd128, 1'b0);
      add_request(8'd0, 1'b0);
      add_request(8'd255, 1'b1);

      drain_and_write(8'd0);
      add_request(8'd255, 1'b0);
      add_request(8'd0, 1'b1);
      add_request(8'd128, 1'b0);
      add_request(8'd1, 1'b0);
      add_request(8'd254, 1'b1);

      drain_and_write(8'd255);
      add_request(8'd0, 1'b0);
      add_request(8'd255, 1'b1);

      drain_and_write(TRACK_W'($urandom_range(255)));
      add_random_batches(RANDOM_BUDGET);
      // fill the table, then drop one beat without and one with batch_end
      for (int i = 0; i < MAX_REQ + 2; i++)
         add_request(TRACK_W'($urandom_range(255)), i == MAX_REQ + 1);

      drain_and_write(TRACK_W'($urandom_range(255)));
      sender_idle_pct = SENDER_IDLE_HEAVY;
      add_random_batches(RANDOM_BUDGET);

      drain_and_write(TRACK_W'($urandom_range(255)));
      sender_idle_pct = 0;
      add_random_batches(RANDOM_BUDGET);

      while (pending_requests.size() != 0 || start) @(posedge clock);
      while (expected_visits.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_sstf_disk_request_scheduler OK");
      end else begin
         $display("tb_sstf_disk_request_scheduler NOT OK");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_sstf_disk_request_scheduler NOT OK");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/sstf_pkg.sv
sv/sstf_ctrl.sv
sv/sstf_datapath.sv
sv/sstf_disk_request_scheduler.sv
dv/tb_sstf_disk_request_scheduler.sv
